// ===== sv/pbt_pkg.sv =====
// Shared types and codes for the port binding table.
// Holds request/entry structs, mode and status codes; no dependencies.
`timescale 1ns / 1ps

package pbt_pkg;

    localparam int MODE_W   = 2;
    localparam int PORT_W   = 16;
    localparam int IFC_W    = 8;
    localparam int SOCK_W   = 16;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_BIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNBIND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    // one stored binding
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [IFC_W-1:0]  ifc;
        logic [SOCK_W-1:0] sock;
    } t_entry;

    // one latched request
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PORT_W-1:0] port;
        logic [IFC_W-1:0]  ifc;
        logic [SOCK_W-1:0] sock;
    } t_req;

endpackage

// ===== sv/pbt_mem.sv =====
// Binding storage: one write port, one read port with registered data.
// Depends on pbt_pkg for the entry type.
`timescale 1ns / 1ps

module pbt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pbt_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pbt_pkg::t_entry o_rdata
);
    import pbt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pbt_match.sv =====
// Shared compare unit: tests one stored entry against the latched request.
// Depends on pbt_pkg for request/entry types and mode codes.
`timescale 1ns / 1ps

module pbt_match (
    input  pbt_pkg::t_req   i_req,
    input  pbt_pkg::t_entry i_entry,
    output logic            o_hit
);
    import pbt_pkg::*;

    logic w_port_eq;
    logic w_ifc_ovl;

    assign w_port_eq = (i_entry.port == i_req.port);
    // interfaces overlap when either side is a wildcard or both agree
    assign w_ifc_ovl = (i_req.ifc == '0) || (i_entry.ifc == '0) || (i_entry.ifc == i_req.ifc);

    // pick the test for the request kind
    always_comb begin
        unique case (i_req.mode)
            MODE_BIND:   o_hit = w_port_eq && w_ifc_ovl;
            MODE_UNBIND: o_hit = (i_entry.sock == i_req.sock);
            MODE_LOOKUP: o_hit = w_port_eq;
            default:     o_hit = 1'b0;
        endcase
    end

endmodule

// ===== sv/port_binding_table_core.sv =====
// Port binding table top level: sequencer over the binding memory and compare unit.
// Depends on pbt_pkg, pbt_mem and pbt_match.
// A bind of port 0 or a reserved mode strobes its result the cycle after start.
// Other items scan newest to oldest through the single read port: an issue step, then one
// compare per entry; the strobe comes once the scan is exhausted, earlier on a hit.
// An unbind below the newest entry then moves each newer entry down one slot.
// One item at a time; busy drops as the result strobe rises; no stall input.
// Reset (synchronous, active low) empties the table; entries need no clearing.
`timescale 1ns / 1ps

module port_binding_table_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [pbt_pkg::MODE_W-1:0]     i_mode,
    input  logic [pbt_pkg::PORT_W-1:0]     i_port,
    input  logic [pbt_pkg::IFC_W-1:0]      i_interface_req,
    input  logic [pbt_pkg::SOCK_W-1:0]     i_socket_id,
    output logic                           busy,
    output logic                           o_valid,
    output logic [pbt_pkg::STATUS_W-1:0]   o_status,
    output logic [pbt_pkg::SOCK_W-1:0]     o_found_socket
);
    import pbt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    // Physical slot count-1 holds the newest binding, slot 0 the oldest.
    t_state              r_state,  n_state;
    t_req                r_req,    n_req;
    logic [CW-1:0]       r_count,  n_count;
    logic [AW-1:0]       r_addr,   n_addr;
    logic [AW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_pend,   n_pend;
    logic                r_rd_vld, n_rd_vld;
    logic                r_valid,  n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SOCK_W-1:0]   r_found,  n_found;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    t_entry              w_rdata;
    logic                w_hit;
    logic [AW-1:0]       w_last;

    assign w_last = AW'(r_count - CW'(1));

    pbt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    pbt_match u_match (
        .i_req   (r_req),
        .i_entry (w_rdata),
        .o_hit   (w_hit)
    );

    // sequence scans and compaction
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_addr   = r_addr;
        n_rd_idx = r_rd_idx;
        n_pend   = r_pend;
        n_rd_vld = r_rd_vld;
        n_valid  = 1'b0;
        n_status = r_status;
        n_found  = '0;
        w_we     = 1'b0;
        w_waddr  = r_rd_idx;
        w_wdata  = '{port: r_req.port, ifc: r_req.ifc, sock: r_req.sock};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = '{mode: i_mode, port: i_port, ifc: i_interface_req,
                              sock: i_socket_id};
                    if (i_mode == MODE_BIND && i_port == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_BUSY;
                    end else if (i_mode == MODE_RSVD) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                    end else begin
                        n_state  = S_SCAN;
                        n_addr   = w_last;
                        n_pend   = (r_count != '0);
                        n_rd_vld = 1'b0;
                    end
                end
            end

            S_SCAN: begin
                if (r_rd_vld && w_hit) begin
                    // newest match found
                    case (r_req.mode)
                        MODE_LOOKUP: begin
                            n_state  = S_IDLE;
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                            n_found  = w_rdata.sock;
                        end
                        MODE_UNBIND: begin
                            if (r_rd_idx == w_last) begin
                                n_state  = S_IDLE;
                                n_valid  = 1'b1;
                                n_status = ST_OK;
                                n_count  = r_count - CW'(1);
                            end else begin
                                n_state  = S_SHIFT;
                                n_addr   = r_rd_idx + AW'(1);
                                n_pend   = 1'b1;
                                n_rd_vld = 1'b0;
                            end
                        end
                        default: begin
                            n_state  = S_IDLE;
                            n_valid  = 1'b1;
                            n_status = ST_BUSY;
                        end
                    endcase
                end else if (!r_pend) begin
                    // scan exhausted without a match
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    case (r_req.mode)
                        MODE_LOOKUP: n_status = ST_MISS;
                        MODE_BIND: begin
                            if (r_count == CW'(TABLE_ENTRIES)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                w_we     = 1'b1;
                                w_waddr  = r_count[AW-1:0];
                                n_count  = r_count + CW'(1);
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end else begin
                    // issue the next older entry
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                    if (r_addr == '0) begin
                        n_pend = 1'b0;
                    end else begin
                        n_addr = r_addr - AW'(1);
                    end
                end
            end

            S_SHIFT: begin
                // move each newer entry down one slot over the removed one
                if (r_rd_vld) begin
                    w_we    = 1'b1;
                    w_waddr = r_rd_idx - AW'(1);
                    w_wdata = w_rdata;
                end
                if (r_rd_vld && !r_pend) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_count  = r_count - CW'(1);
                end else begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                    if (r_addr == w_last) begin
                        n_pend = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_status <= n_status;
        r_found  <= n_found;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_socket = r_found;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_found_socket == '0))
        else $error("socket reported on a failed request");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("binding count above table size");

    a_shift_unbind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_req.mode == MODE_UNBIND && r_count != '0))
        else $error("compaction outside an unbind");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for port_binding_table_core: bind, unbind and lookup items checked
// against an in-bench model of the ordered binding table. Depends on pbt_pkg.

module tb;
    import pbt_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SOCK_W-1:0]   sock;
    } t_reply;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic [MODE_W-1:0]   i_mode          = MODE_RSVD;
    logic [PORT_W-1:0]   i_port          = '0;
    logic [IFC_W-1:0]    i_interface_req = '0;
    logic [SOCK_W-1:0]   i_socket_id     = '0;
    logic                busy;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SOCK_W-1:0]   o_found_socket;

    // model of the binding table: slot 0 is the newest binding
    t_entry bindings [TABLE_ENTRIES];
    int     n_bound  = 0;
    t_reply replies_due [$];
    int     err_cnt  = 0;
    int     cyc_cnt  = 0;
    int     idle_pct = 0;

    port_binding_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_mode         (i_mode),
        .i_port         (i_port),
        .i_interface_req(i_interface_req),
        .i_socket_id    (i_socket_id),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_socket (o_found_socket)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // bound the run in case the block hangs
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTED)
            $display("tb: mismatch at cycle %0d: %s", cyc_cnt, msg);
    endtask

    function automatic t_req make_req(input logic [MODE_W-1:0] mode,
                                      input logic [PORT_W-1:0] port,
                                      input logic [IFC_W-1:0]  ifc,
                                      input logic [SOCK_W-1:0] sock);
        t_req r;
        r.mode = mode;
        r.port = port;
        r.ifc  = ifc;
        r.sock = sock;
        return r;
    endfunction

    // Apply one item to the table model and return the reply it should give.
    function automatic t_reply apply_request(input t_req r);
        t_reply rep;
        bit     clash;
        int     hit;
        rep.status = ST_OK;
        rep.sock   = '0;
        clash      = 1'b0;
        hit        = -1;
        case (r.mode)
            MODE_BIND: begin
                for (int i = 0; i < n_bound; i++) begin
                    if (bindings[i].port == r.port &&
                        (r.ifc == '0 || bindings[i].ifc == '0 || bindings[i].ifc == r.ifc))
                        clash = 1'b1;
                end
                if (r.port == '0 || clash) begin
                    rep.status = ST_BUSY;
                end else if (n_bound >= TABLE_ENTRIES) begin
                    rep.status = ST_FULL;
                end else begin
                    for (int i = n_bound; i > 0; i--)
                        bindings[i] = bindings[i-1];
                    bindings[0].port = r.port;
                    bindings[0].ifc  = r.ifc;
                    bindings[0].sock = r.sock;
                    n_bound++;
                end
            end
            MODE_UNBIND: begin
                // remove the newest binding of the socket, close the gap
                for (int i = 0; i < n_bound; i++) begin
                    if (hit < 0 && bindings[i].sock == r.sock)
                        hit = i;
                end
                if (hit >= 0) begin
                    for (int j = hit; j + 1 < n_bound; j++)
                        bindings[j] = bindings[j+1];
                    n_bound--;
                end
            end
            MODE_LOOKUP: begin
                rep.status = ST_MISS;
                for (int i = 0; i < n_bound; i++) begin
                    if (hit < 0 && bindings[i].port == r.port) begin
                        hit        = i;
                        rep.status = ST_OK;
                        rep.sock   = bindings[i].sock;
                    end
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Drive one item after an optional idle gap; return once busy is seen low.
    task automatic send_item(input t_req r);
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_mode          <= r.mode;
        i_port          <= r.port;
        i_interface_req <= r.ifc;
        i_socket_id     <= r.sock;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        replies_due.push_back(apply_request(r));
    endtask

    // Drop start and hold off until every expected reply has arrived.
    task automatic wait_replies();
        @(negedge i_clk);
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Check each reply against the oldest expectation.
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                report_mismatch("reply with no item outstanding");
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_found_socket !== want.sock)
                    report_mismatch($sformatf("found_socket %0h, want %0h",
                                              o_found_socket, want.sock));
            end
        end
    end

    function automatic logic [PORT_W-1:0] pick_port();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return '0;
        if (roll < 80) begin
            case ($urandom_range(7))
                0: return 16'd1;
                1: return 16'd7;
                2: return 16'd80;
                3: return 16'd443;
                4: return 16'd1024;
                5: return 16'h8000;
                6: return 16'hA5A5;
                default: return 16'hFFFF;
            endcase
        end
        return PORT_W'($urandom_range(65535));
    endfunction

    // Mostly well-formed traffic: few ports, few interfaces, live sockets.
    function automatic t_req random_request(input int bind_pct, input int unbind_pct);
        t_req r;
        int   roll;
        roll   = $urandom_range(99);
        r.port = pick_port();
        if ($urandom_range(99) < 70)
            r.ifc = IFC_W'($urandom_range(3));
        else
            r.ifc = IFC_W'($urandom_range(255));
        if ($urandom_range(99) < 70)
            r.sock = SOCK_W'($urandom_range(32, 1));
        else
            r.sock = SOCK_W'($urandom_range(65535));
        if (roll < bind_pct) begin
            r.mode = MODE_BIND;
        end else if (roll < bind_pct + unbind_pct) begin
            r.mode = MODE_UNBIND;
            if (n_bound > 0 && $urandom_range(99) < 75)
                r.sock = bindings[$urandom_range(n_bound - 1)].sock;
        end else if (roll < 95) begin
            r.mode = MODE_LOOKUP;
            if (n_bound > 0 && $urandom_range(99) < 40)
                r.port = bindings[$urandom_range(n_bound - 1)].port;
        end else begin
            r.mode = MODE_RSVD;
        end
        return r;
    endfunction

    // Lookups on an empty table, a port-zero bind, reserved mode with all ones, an unbind.
    task automatic test_empty_table();
        send_item(make_req(MODE_LOOKUP, 16'd5, 8'd0, 16'd0));
        send_item(make_req(MODE_LOOKUP, 16'd0, 8'd0, 16'd0));
        send_item(make_req(MODE_BIND, 16'd0, 8'd1, 16'd9));
        send_item(make_req(MODE_RSVD, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_item(make_req(MODE_UNBIND, 16'd0, 8'd0, 16'd9));
    endtask

    // Wildcard and equal-interface clashes on the same port.
    task automatic test_bind_conflicts();
        send_item(make_req(MODE_BIND, 16'd100, 8'd0, 16'd1));
        send_item(make_req(MODE_BIND, 16'd100, 8'd5, 16'd2));
        send_item(make_req(MODE_BIND, 16'd200, 8'd3, 16'd3));
        send_item(make_req(MODE_BIND, 16'd200, 8'd3, 16'd4));
        send_item(make_req(MODE_BIND, 16'd200, 8'd0, 16'd5));
        send_item(make_req(MODE_BIND, 16'd200, 8'd4, 16'd6));
        send_item(make_req(MODE_LOOKUP, 16'd200, 8'd0, 16'd0));
        send_item(make_req(MODE_LOOKUP, 16'd100, 8'd0, 16'd0));
    endtask

    // Unbind takes the newest binding of a socket; a missing socket is a no-op.
    task automatic test_unbind_order();
        send_item(make_req(MODE_BIND, 16'd300, 8'd1, 16'd6));
        send_item(make_req(MODE_UNBIND, 16'd0, 8'd0, 16'd6));
        send_item(make_req(MODE_LOOKUP, 16'd300, 8'd0, 16'd0));
        send_item(make_req(MODE_LOOKUP, 16'd200, 8'd0, 16'd0));
        send_item(make_req(MODE_UNBIND, 16'd0, 8'd0, 16'd999));
        send_item(make_req(MODE_BIND, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_item(make_req(MODE_LOOKUP, 16'hFFFF, 8'h00, 16'h0000));
        send_item(make_req(MODE_UNBIND, 16'hFFFF, 8'hFF, 16'hFFFF));
    endtask

    // Fill the table, then check full versus clash priority and drain it.
    task automatic test_full_table();
        int k;
        k = 0;
        while (n_bound < TABLE_ENTRIES) begin
            send_item(make_req(MODE_BIND, PORT_W'(2000 + k), IFC_W'(1 + k),
                               SOCK_W'(600 + k)));
            k++;
        end
        send_item(make_req(MODE_BIND, 16'd3000, 8'd1, 16'd700));
        send_item(make_req(MODE_BIND, 16'd2000, 8'd0, 16'd701));
        send_item(make_req(MODE_LOOKUP, 16'd2000, 8'd0, 16'd0));
        wait_replies();
        while (n_bound > 0)
            send_item(make_req(MODE_UNBIND, 16'd0, 8'd0, bindings[n_bound - 1].sock));
        wait_replies();
    endtask

    task automatic run_phase(input int items, input int idle, input int bind_pct,
                             input int unbind_pct);
        idle_pct = idle;
        repeat (items)
            send_item(random_request(bind_pct, unbind_pct));
        wait_replies();
    endtask

    // Fill-heavy, mixed and drain-heavy phases under varying sender gaps.
    task automatic test_random_traffic();
        run_phase(400, 0, 55, 15);
        run_phase(400, 60, 35, 30);
        run_phase(400, 0, 25, 45);
        run_phase(500, 33, 45, 25);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_bind_conflicts();
        test_unbind_order();
        wait_replies();
        test_full_table();
        test_random_traffic();
        wait_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && replies_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
